// ===== rtl/core/afsm_pkg.sv =====
// Shared types and constants for the arming and failsafe supervisor.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package afsm_pkg;

    // Opcodes of an input request
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ARM    = 2'd1;
    localparam logic [1:0] OP_DISARM = 2'd2;
    localparam logic [1:0] OP_KILL   = 2'd3;

    // Arm state codes
    localparam logic [1:0] ST_DISARMED   = 2'd0;
    localparam logic [1:0] ST_ARMED      = 2'd1;
    localparam logic [1:0] ST_FAILSAFE   = 2'd2;
    localparam logic [1:0] ST_FAULT_LOCK = 2'd3;

    // Failsafe reason codes
    localparam logic [2:0] RS_NONE        = 3'd0;
    localparam logic [2:0] RS_BATTERY     = 3'd1;
    localparam logic [2:0] RS_IMU_TIMEOUT = 3'd2;
    localparam logic [2:0] RS_IMU_PARSE   = 3'd3;
    localparam logic [2:0] RS_OVERRUN     = 3'd4;
    localparam logic [2:0] RS_RC_LOSS     = 3'd5;
    localparam logic [2:0] RS_KILL        = 3'd6;

    // IMU health codes
    localparam logic [1:0] IMU_OK          = 2'd0;
    localparam logic [1:0] IMU_TIMEOUT     = 2'd1;
    localparam logic [1:0] IMU_PARSE_ERROR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_CRITICAL_MV       = 2'd0;
    localparam logic [1:0] CFG_ARM_MIN_MV        = 2'd1;
    localparam logic [1:0] CFG_PARSE_ERROR_LIMIT = 2'd2;
    localparam logic [1:0] CFG_OVERRUN_LIMIT     = 2'd3;

    // Configuration reset values
    localparam logic [15:0] CRITICAL_MV_RST       = 16'd3300;
    localparam logic [15:0] ARM_MIN_MV_RST        = 16'd3600;
    localparam logic [15:0] PARSE_ERROR_LIMIT_RST = 16'd10;
    localparam logic [15:0] OVERRUN_LIMIT_RST     = 16'd100;

    // Fixed thresholds
    localparam logic [15:0] NO_READING_MV      = 16'd100;
    localparam logic [9:0]  ARM_THROTTLE_LIMIT = 10'd50;

    // Low-battery streak counter width (debounce length up to 127)
    localparam int STREAK_W = 7;

    typedef struct packed {
        logic [15:0] critical_mv;
        logic [15:0] arm_min_mv;
        logic [15:0] parse_error_limit;
        logic [15:0] overrun_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        no_rc_arm_ok;
        logic [15:0] battery_mv;
        logic [1:0]  imu_status;
        logic [15:0] parse_error_run;
        logic [15:0] overrun_count;
        logic        radio_link_up;
        logic [9:0]  throttle_permille;
    } t_item;

    typedef struct packed {
        logic [1:0] flight_mode;
        logic [2:0] fault_cause;
        logic       motors_stop;
        logic       request_accepted;
    } t_result;

endpackage

// ===== rtl/core/arming_failsafe_state_machine_core.sv =====
// Top level of the arming and failsafe supervisor: input register,
// supervisor core, output register. Depends on afsm_pkg, afsm_cfg, afsm_ctrl.
`timescale 1ns / 1ps

// Usage
// - Request channel: i_in_valid with the request fields; a request is taken at
//   a rising edge where i_in_valid is high and o_in_stall is low.
// - Result channel: o_out_valid with the result fields; a result is taken at a
//   rising edge where o_out_valid is high and i_out_stall is low.
// - Configuration: i_cfg_valid, i_cfg_index, i_cfg_data; o_cfg_ready is always
//   high, so a write lands at every edge with i_cfg_valid high. Write only
//   while no request is in flight.
// - Path: with no stall a request passes through the input register, then the
//   result register, which holds its result until it is taken. Throughput:
//   one request per cycle while i_out_stall is low, set by the combinational
//   next-state logic between the two registers.
// - Stall: while i_out_stall holds a result, one more request is taken into
//   the input register; o_in_stall then rises until the result drains.
// - Reset (synchronous, i_rst_n low): both registers empty, state disarmed,
//   reason none, pending requests and battery streak cleared, configuration
//   back to its reset values.
module arming_failsafe_state_machine_core
    import afsm_pkg::*;
#(
    parameter int DEBOUNCE_TICKS = 100
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic        i_no_rc_arm_ok,
    input  logic [15:0] i_battery_mv,
    input  logic [1:0]  i_imu_status,
    input  logic [15:0] i_parse_error_run,
    input  logic [15:0] i_overrun_count,
    input  logic        i_radio_link_up,
    input  logic [9:0]  i_throttle_permille,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_flight_mode,
    output logic [2:0]  o_fault_cause,
    output logic        o_motors_stop,
    output logic        o_request_accepted,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic    r_in_valid, n_in_valid;
    t_item   r_in;
    logic    r_out_valid, n_out_valid;
    t_result r_out;

    logic    in_accept;
    logic    advance;
    logic    fire;
    t_cfg    cfg;
    t_result result;

    // The result register may load when it is empty or being drained now
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    afsm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    afsm_ctrl #(
        .DEBOUNCE_TICKS (DEBOUNCE_TICKS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register: load on accept, drop once its request fires
    always_comb begin
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    // Result register: load on fire, drop once taken
    always_comb begin
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: hold unless a new request or result is loaded
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.opcode            <= i_opcode;
            r_in.no_rc_arm_ok      <= i_no_rc_arm_ok;
            r_in.battery_mv        <= i_battery_mv;
            r_in.imu_status        <= i_imu_status;
            r_in.parse_error_run   <= i_parse_error_run;
            r_in.overrun_count     <= i_overrun_count;
            r_in.radio_link_up     <= i_radio_link_up;
            r_in.throttle_permille <= i_throttle_permille;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_flight_mode      = r_out.flight_mode;
    assign o_fault_cause      = r_out.fault_cause;
    assign o_motors_stop      = r_out.motors_stop;
    assign o_request_accepted = r_out.request_accepted;

    // Never overwrite a result that is still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fire && r_out_valid && i_out_stall))
        else $error("result register overwritten while stalled");

    // Stall only when a request is actually waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("request stall without a blocked request");

    // Motor stop follows the reported state
    a_motor_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_motors_stop == (o_flight_mode != ST_ARMED)))
        else $error("motor stop disagrees with arm state");

    // A fired request shows its result in the next cycle
    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("fired request left no result");

endmodule

// ===== rtl/core/afsm_cfg.sv =====
// Configuration register file of the arming and failsafe supervisor.
// Depends on afsm_pkg for register indexes, reset values and t_cfg.
`timescale 1ns / 1ps

module afsm_cfg
    import afsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [1:0]  i_wr_index,
    input  logic [15:0] i_wr_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_index)
                CFG_CRITICAL_MV:       n_cfg.critical_mv       = i_wr_data;
                CFG_ARM_MIN_MV:        n_cfg.arm_min_mv        = i_wr_data;
                CFG_PARSE_ERROR_LIMIT: n_cfg.parse_error_limit = i_wr_data;
                CFG_OVERRUN_LIMIT:     n_cfg.overrun_limit     = i_wr_data;
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.critical_mv       <= CRITICAL_MV_RST;
            r_cfg.arm_min_mv        <= ARM_MIN_MV_RST;
            r_cfg.parse_error_limit <= PARSE_ERROR_LIMIT_RST;
            r_cfg.overrun_limit     <= OVERRUN_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/afsm_ctrl.sv =====
// Supervisor state and next-state logic: pending requests, arm state,
// failsafe reason and low-battery debounce. Depends on afsm_pkg.
`timescale 1ns / 1ps

module afsm_ctrl
    import afsm_pkg::*;
#(
    parameter int DEBOUNCE_TICKS = 100
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam logic [STREAK_W-1:0] DEB = STREAK_W'(DEBOUNCE_TICKS);

    logic [1:0]          r_state,      n_state;
    logic [2:0]          r_reason,     n_reason;
    logic                r_arm_pend,   n_arm_pend;
    logic                r_dis_pend,   n_dis_pend;
    logic                r_kill_pend,  n_kill_pend;
    logic                r_ovr_pend,   n_ovr_pend;
    logic                r_ovr_act,    n_ovr_act;
    logic [STREAK_W-1:0] r_streak,     n_streak;

    logic                no_reading;
    logic [STREAK_W-1:0] streak_upd;
    logic [2:0]          found;
    logic                may_arm;
    logic                accepted;

    // Battery debounce and reason search, ordered by priority
    always_comb begin
        no_reading = (i_item.battery_mv <= NO_READING_MV);
        if (no_reading || (i_item.battery_mv > i_cfg.critical_mv)) begin
            streak_upd = '0;
        end else if (r_streak < DEB) begin
            streak_upd = r_streak + 1'b1;
        end else begin
            streak_upd = r_streak;
        end

        if (streak_upd >= DEB) begin
            found = RS_BATTERY;
        end else if (i_item.imu_status == IMU_TIMEOUT) begin
            found = RS_IMU_TIMEOUT;
        end else if ((i_item.imu_status == IMU_PARSE_ERROR) ||
                     (i_item.parse_error_run >= i_cfg.parse_error_limit)) begin
            found = RS_IMU_PARSE;
        end else if (i_item.overrun_count >= i_cfg.overrun_limit) begin
            found = RS_OVERRUN;
        end else if ((r_state == ST_ARMED) && !i_item.radio_link_up && !r_ovr_act) begin
            found = RS_RC_LOSS;
        end else begin
            found = RS_NONE;
        end

        may_arm = (i_item.throttle_permille < ARM_THROTTLE_LIMIT) &&
                  (i_item.imu_status == IMU_OK) &&
                  (no_reading || (i_item.battery_mv > i_cfg.arm_min_mv)) &&
                  (i_item.radio_link_up || r_ovr_pend);
    end

    always_comb begin
        n_state     = r_state;
        n_reason    = r_reason;
        n_arm_pend  = r_arm_pend;
        n_dis_pend  = r_dis_pend;
        n_kill_pend = r_kill_pend;
        n_ovr_pend  = r_ovr_pend;
        n_ovr_act   = r_ovr_act;
        n_streak    = r_streak;
        accepted    = 1'b1;

        case (i_item.opcode)
            OP_ARM: begin
                if (r_state == ST_FAULT_LOCK) begin
                    accepted = 1'b0;
                end else begin
                    n_arm_pend = 1'b1;
                    n_ovr_pend = i_item.no_rc_arm_ok;
                end
            end
            OP_DISARM: begin
                n_dis_pend = 1'b1;
            end
            OP_KILL: begin
                n_kill_pend = 1'b1;
            end
            OP_TICK: begin
                if (r_kill_pend) begin
                    n_state    = ST_FAULT_LOCK;
                    n_reason   = RS_KILL;
                    n_ovr_act  = 1'b0;
                    n_streak   = '0;
                end else if (r_state != ST_FAULT_LOCK) begin
                    n_streak = streak_upd;
                    if (found != RS_NONE) begin
                        n_state  = ST_FAILSAFE;
                        n_reason = found;
                    end
                    if (r_dis_pend) begin
                        n_state   = ST_DISARMED;
                        n_reason  = RS_NONE;
                        n_ovr_act = 1'b0;
                        n_streak  = '0;
                    end
                    if (r_arm_pend && (n_state == ST_DISARMED) && may_arm) begin
                        n_state   = ST_ARMED;
                        n_reason  = RS_NONE;
                        n_ovr_act = r_ovr_pend;
                    end
                end
                n_kill_pend = 1'b0;
                n_arm_pend  = 1'b0;
                n_dis_pend  = 1'b0;
                n_ovr_pend  = 1'b0;
            end
            default: begin
                accepted = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_DISARMED;
            r_reason    <= RS_NONE;
            r_arm_pend  <= 1'b0;
            r_dis_pend  <= 1'b0;
            r_kill_pend <= 1'b0;
            r_ovr_pend  <= 1'b0;
            r_ovr_act   <= 1'b0;
            r_streak    <= '0;
        end else if (i_fire) begin
            r_state     <= n_state;
            r_reason    <= n_reason;
            r_arm_pend  <= n_arm_pend;
            r_dis_pend  <= n_dis_pend;
            r_kill_pend <= n_kill_pend;
            r_ovr_pend  <= n_ovr_pend;
            r_ovr_act   <= n_ovr_act;
            r_streak    <= n_streak;
        end
    end

    assign o_result.flight_mode      = n_state;
    assign o_result.fault_cause      = n_reason;
    assign o_result.motors_stop      = (n_state != ST_ARMED);
    assign o_result.request_accepted = accepted;

    // Fault lock is left only through reset
    a_lock_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FAULT_LOCK) |=> (r_state == ST_FAULT_LOCK))
        else $error("fault lock was left without reset");

    // Reason matches the state it belongs to
    a_reason_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (((r_state == ST_DISARMED) || (r_state == ST_ARMED)) && (r_reason == RS_NONE)) ||
        ((r_state == ST_FAULT_LOCK) && (r_reason == RS_KILL)) ||
        ((r_state == ST_FAILSAFE) && (r_reason != RS_NONE) && (r_reason != RS_KILL)))
        else $error("stored reason inconsistent with arm state");

    // Debounce counter saturates at the debounce length
    a_streak_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_streak <= DEB)
        else $error("low battery streak above debounce length");

    // A tick always clears the pending override and pending arm flags
    a_ovr_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_item.opcode == OP_TICK)) |=> !r_ovr_pend && !r_arm_pend)
        else $error("pending arm or override survived a tick");

endmodule
